[rtl/core/counting_semaphore_wait_queue_unit_macros.svh]
// Assertion macros for the semaphore wait queue unit checker.
`ifndef COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH
`define COUNTING_SEMAPHORE_WAIT_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSW_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define CSW_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/csw_pkg.sv]
// Shared types and constants for the semaphore wait queue unit.
`timescale 1ns / 1ps
package csw_pkg;

  localparam int SEMA_W    = 3;
  localparam int TASK_W    = 4;
  localparam int INIT_W    = 15;
  localparam int CNT_W     = 16;
  localparam int NUM_SEMAS = 1 << SEMA_W;
  localparam int NUM_TASKS = 1 << TASK_W;

  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 24;

  localparam logic signed [CNT_W-1:0] CNT_MAX = {1'b0, {(CNT_W-1){1'b1}}};
  localparam logic signed [CNT_W-1:0] CNT_MIN = {1'b1, {(CNT_W-1){1'b0}}};

  typedef enum logic [1:0] {
    REQ_WAIT    = 2'd0,
    REQ_SIGNAL  = 2'd1,
    REQ_CREATE  = 2'd2,
    REQ_DESTROY = 2'd3
  } req_type_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BUSY   = 2'd1,
    ST_NOSLOT = 2'd2
  } status_t;

  typedef struct packed {
    req_type_t           req_type;
    logic [SEMA_W-1:0]   sema_index;
    logic [TASK_W-1:0]   task_id;
    logic [INIT_W-1:0]   start_count;
  } req_t;

  typedef struct packed {
    status_t                  status;
    logic                     task_blocked;
    logic                     woken_valid;
    logic [TASK_W-1:0]        woken_task;
    logic signed [CNT_W-1:0]  count_after;
  } rsp_t;

endpackage

[rtl/core/counting_semaphore_wait_queue_unit.sv]
// Top level of the counting semaphore unit with FIFO wait queues.
`timescale 1ns / 1ps
// Eight counting semaphores with signed 16-bit saturating counts, each with a
// FIFO of waiting task numbers linked through one next-pointer per task. Every
// request word (wait, signal, create, destroy) gives exactly one result word.
// A request is registered on entry; its slot is read, updated and written back
// as the output register takes the result. One request per cycle is sustained
// while the sink keeps out_tready high; the rate is set by the read-modify-write
// of the addressed slot's count, head, tail and one next-pointer entry. Slot
// state is live right after reset; no clearing pass. Wait, signal and destroy
// requests to a slot not created (or since destroyed) return status 2.
module counting_semaphore_wait_queue_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [2:0] sema_index, [6:3] task_id, [21:7] start_count, [23:22] zero
  input  logic [csw_pkg::IN_DATA_W-1:0]   in_tdata,
  // [1:0] req_type
  input  logic [1:0]                      in_tuser,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] task_blocked, [1] woken_valid, [5:2] woken_task, [21:6] count_after,
  // [23:22] zero
  output logic [csw_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [1:0] status
  output logic [1:0]                      out_tuser
);

  logic          req_valid;
  logic          can_take;
  logic          advance;
  csw_pkg::req_t req;
  csw_pkg::rsp_t rsp;

  assign advance = req_valid && can_take;

  csw_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  csw_sema_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (advance),
    .req   (req),
    .rsp   (rsp)
  );

  csw_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (advance),
    .rsp        (rsp),
    .can_take   (can_take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

endmodule

[rtl/core/csw_in_stage.sv]
// Input register stage: captures one request word per cycle unless the held word is stalled.
`timescale 1ns / 1ps
module csw_in_stage (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [csw_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic [1:0]                     in_tuser,
  input  logic                           advance,
  output logic                           req_valid,
  output csw_pkg::req_t                  req
);

  logic          valid_r;
  csw_pkg::req_t req_r;
  csw_pkg::req_t req_nxt;

  assign in_tready = !valid_r || advance;

  always_comb begin
    req_nxt.req_type    = csw_pkg::req_type_t'(in_tuser);
    req_nxt.sema_index  = in_tdata[csw_pkg::SEMA_W-1:0];
    req_nxt.task_id     = in_tdata[csw_pkg::SEMA_W +: csw_pkg::TASK_W];
    req_nxt.start_count = in_tdata[csw_pkg::SEMA_W + csw_pkg::TASK_W +: csw_pkg::INIT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      req_r <= req_nxt;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

[rtl/core/csw_sema_core.sv]
// Semaphore slot state, linked wait queues and the per-request update logic.
`timescale 1ns / 1ps
module csw_sema_core (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          fire,
  input  csw_pkg::req_t req,
  output csw_pkg::rsp_t rsp
);

  logic signed [csw_pkg::CNT_W-1:0]  cnt_r  [csw_pkg::NUM_SEMAS];
  logic [csw_pkg::NUM_SEMAS-1:0]     use_r;
  logic [csw_pkg::NUM_SEMAS-1:0]     ne_r;
  logic [csw_pkg::TASK_W-1:0]        head_r [csw_pkg::NUM_SEMAS];
  logic [csw_pkg::TASK_W-1:0]        tail_r [csw_pkg::NUM_SEMAS];
  logic [csw_pkg::TASK_W-1:0]        link_r [csw_pkg::NUM_TASKS];

  logic signed [csw_pkg::CNT_W-1:0]  cnt;
  logic                              in_use;
  logic                              nonempty;
  logic [csw_pkg::TASK_W-1:0]        head;
  logic [csw_pkg::TASK_W-1:0]        tail;
  logic signed [csw_pkg::CNT_W-1:0]  cnt_dec;
  logic signed [csw_pkg::CNT_W-1:0]  cnt_inc;

  logic signed [csw_pkg::CNT_W-1:0]  cnt_nxt;
  logic                              use_nxt;
  logic                              ne_nxt;
  logic [csw_pkg::TASK_W-1:0]        head_nxt;
  logic [csw_pkg::TASK_W-1:0]        tail_nxt;
  logic                              link_we;

  assign cnt      = cnt_r[req.sema_index];
  assign in_use   = use_r[req.sema_index];
  assign nonempty = ne_r[req.sema_index];
  assign head     = head_r[req.sema_index];
  assign tail     = tail_r[req.sema_index];
  assign cnt_dec  = (cnt != csw_pkg::CNT_MIN) ? cnt - 16'sd1 : cnt;
  assign cnt_inc  = (cnt != csw_pkg::CNT_MAX) ? cnt + 16'sd1 : cnt;

  always_comb begin
    cnt_nxt  = cnt;
    use_nxt  = in_use;
    ne_nxt   = nonempty;
    head_nxt = head;
    tail_nxt = tail;
    link_we  = 1'b0;
    rsp      = '0;
    rsp.status = csw_pkg::ST_OK;
    if (req.req_type == csw_pkg::REQ_CREATE) begin
      cnt_nxt         = {1'b0, req.start_count};
      use_nxt         = 1'b1;
      ne_nxt          = 1'b0;
      rsp.count_after = {1'b0, req.start_count};
    end else if (!in_use) begin
      rsp.status = csw_pkg::ST_NOSLOT;
    end else begin
      unique case (req.req_type)
        csw_pkg::REQ_WAIT: begin
          cnt_nxt         = cnt_dec;
          rsp.count_after = cnt_dec;
          if (cnt_dec[csw_pkg::CNT_W-1]) begin
            // append at tail; an empty queue takes the task as head
            if (nonempty) begin
              link_we = 1'b1;
            end else begin
              head_nxt = req.task_id;
              ne_nxt   = 1'b1;
            end
            tail_nxt         = req.task_id;
            rsp.task_blocked = 1'b1;
          end
        end
        csw_pkg::REQ_SIGNAL: begin
          cnt_nxt         = cnt_inc;
          rsp.count_after = cnt_inc;
          if (nonempty) begin
            rsp.woken_valid = 1'b1;
            rsp.woken_task  = head;
            if (head == tail) begin
              ne_nxt = 1'b0;
            end else begin
              head_nxt = link_r[head];
            end
          end
        end
        csw_pkg::REQ_DESTROY: begin
          rsp.count_after = cnt;
          if (nonempty) begin
            rsp.status = csw_pkg::ST_BUSY;
          end else begin
            use_nxt = 1'b0;
          end
        end
        default: begin
          rsp.status = csw_pkg::ST_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_r <= '0;
      ne_r  <= '0;
      for (int i = 0; i < csw_pkg::NUM_SEMAS; i++) begin
        cnt_r[i] <= '0;
      end
    end else if (fire) begin
      use_r[req.sema_index] <= use_nxt;
      ne_r[req.sema_index]  <= ne_nxt;
      cnt_r[req.sema_index] <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      head_r[req.sema_index] <= head_nxt;
      tail_r[req.sema_index] <= tail_nxt;
      if (link_we) begin
        link_r[tail] <= req.task_id;
      end
    end
  end

endmodule

[rtl/core/csw_out_stage.sv]
// Result register stage: holds one result word until the sink takes it.
`timescale 1ns / 1ps
module csw_out_stage (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            load,
  input  csw_pkg::rsp_t                   rsp,
  output logic                            can_take,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [csw_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic [1:0]                      out_tuser
);

  logic          valid_r;
  csw_pkg::rsp_t rsp_r;

  assign can_take = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      rsp_r <= rsp;
    end
  end

  assign out_tvalid = valid_r;
  assign out_tuser  = rsp_r.status;
  assign out_tdata  = {2'b00, rsp_r.count_after, rsp_r.woken_task,
                       rsp_r.woken_valid, rsp_r.task_blocked};

endmodule

[rtl/core/csw_checker.sv]
// Port-level checker for the semaphore unit, bound to the top level.
`timescale 1ns / 1ps
`include "counting_semaphore_wait_queue_unit_macros.svh"
module csw_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [csw_pkg::OUT_DATA_W-1:0]  out_tdata,
  input logic [1:0]                      out_tuser
);

  `CSW_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result word changed while stalled")
  `CSW_ASSERT_NOW(a_noslot_zero, out_tvalid && out_tuser == csw_pkg::ST_NOSLOT, out_tdata == '0, "not-created result carries data")
  `CSW_ASSERT_NOW(a_blocked_neg, out_tvalid && out_tdata[0], out_tdata[21] && !out_tdata[1], "blocked wait with non-negative count")
  `CSW_ASSERT_NOW(a_woken_ok, out_tvalid && !out_tdata[1], out_tdata[5:2] == '0, "woken task set without woken flag")

endmodule

bind counting_semaphore_wait_queue_unit csw_checker u_csw_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
